// ----- rtl/p2prt_pkg.sv -----
// Package for the request/response tracker: sizes, codes and controller states.
// No dependencies.
package p2prt_pkg;

   localparam int Slots = 16;
   localparam int SlotW = 4;
   localparam int Services = 64;
   localparam int SvcW = 6;
   localparam int MaxPayload = 128;

   localparam logic [1:0] TYPE_FRAME = 2'd0;
   localparam logic [1:0] TYPE_TICK  = 2'd1;
   localparam logic [1:0] TYPE_SEND  = 2'd2;
   localparam logic [1:0] TYPE_RESP  = 2'd3;

   localparam logic [1:0] FN_REQ  = 2'd0;
   localparam logic [1:0] FN_ACK  = 2'd1;
   localparam logic [1:0] FN_RSP  = 2'd2;
   localparam logic [1:0] FN_NA   = 2'd3;

   localparam logic [1:0] KIND_HDR = 2'd0;
   localparam logic [1:0] KIND_REP = 2'd1;
   localparam logic [1:0] KIND_REF = 2'd2;

   localparam logic [2:0] RC_OK      = 3'd0;
   localparam logic [2:0] RC_RSP     = 3'd1;
   localparam logic [2:0] RC_ACK_TO  = 3'd2;
   localparam logic [2:0] RC_RSP_TO  = 3'd3;
   localparam logic [2:0] RC_UNAVAIL = 3'd4;

   localparam logic [1:0] CSR_MASK    = 2'd0;
   localparam logic [1:0] CSR_ACK_TO  = 2'd1;
   localparam logic [1:0] CSR_SVC_TO  = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SVC_WALK,
      ST_SLOT_WALK,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic exec;       // run a frame, send or response item
      logic svc_step;   // decrement one service countdown
      logic slot_step;  // tick one slot
      logic finish;     // close the tick
   } cmd_type;

   typedef struct packed {
      logic svc_last;
      logic slot_last;
   } status_type;

endpackage

// ----- rtl/p2prt_ctrl.sv -----
// Controller for the tracker: sequences an item through the datapath.
// Depends on p2prt_pkg.
module p2prt_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [1:0]           req_type,
   input  p2prt_pkg::status_type sts,
   output p2prt_pkg::cmd_type   cmd,
   output logic                 busy
);
   import p2prt_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      busy = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = (req_type == TYPE_TICK) ? ST_SVC_WALK : ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = ST_IDLE;
         end
         ST_SVC_WALK: begin
            cmd.svc_step = 1'b1;
            if (sts.svc_last) state_in = ST_SLOT_WALK;
         end
         ST_SLOT_WALK: begin
            cmd.slot_step = 1'b1;
            if (sts.slot_last) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule

// ----- rtl/p2prt_dp.sv -----
// Datapath for the tracker: service and slot tables, result register.
// Depends on p2prt_pkg.
module p2prt_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic [1:0]             req_type,
   input  logic [5:0]             req_service,
   input  logic [1:0]             req_func,
   input  logic [7:0]             req_frame_id,
   input  logic [7:0]             req_length,
   input  logic                   req_handler_accepts,
   input  logic                   req_wait_for_answer,
   input  logic                   csr_write,
   input  logic [1:0]             csr_index,
   input  logic [63:0]            csr_data,
   input  p2prt_pkg::cmd_type     cmd,
   output p2prt_pkg::status_type  sts,
   output logic                   rsp_valid,
   output logic [1:0]             rsp_out_kind,
   output logic [5:0]             rsp_out_service,
   output logic [1:0]             rsp_out_func,
   output logic [7:0]             rsp_out_id,
   output logic [7:0]             rsp_out_length,
   output logic [2:0]             rsp_report_code,
   output logic                   rsp_last
);
   import p2prt_pkg::*;

   // configuration
   logic [63:0] mask_ff;
   logic [15:0] ack_to_ff, svc_to_ff;
   logic [15:0] ack_eff, svc_eff;

   // held item
   logic [1:0] typ_ff;
   logic [5:0] svc_ff;
   logic [1:0] fn_ff;
   logic [7:0] fid_ff, len_ff;
   logic       acc_ff, wait_ff;

   // tables: services in a memory, slots in flip-flops
   logic [7:0]  srv_id_mem [Services];
   logic [15:0] srv_cd_mem [Services];
   logic [Services-1:0] srv_vld_ff;
   logic [SvcW-1:0] srv_rd_ff;
   logic [7:0]  srv_id_rd;
   logic [15:0] srv_cd_rd;
   logic [SvcW-1:0] walk_ff;

   logic [5:0]  sl_svc_ff  [Slots];
   logic [7:0]  sl_id_ff   [Slots];
   logic [15:0] sl_ack_ff  [Slots];
   logic [15:0] sl_rsp_ff  [Slots];
   logic [Slots-1:0] sl_act_ff;
   logic [SlotW:0]   used_ff;
   logic [SlotW-1:0] sidx_ff;
   logic [4:0]       nrep_ff;
   logic             pend_ff;   // a tick report waits for its last flag

   // pending tick report held back one slot so that last can be set
   logic [5:0] prep_svc_ff;
   logic [7:0] prep_id_ff;
   logic [2:0] prep_code_ff;

   assign ack_eff = (ack_to_ff == 16'd0) ? 16'd1 : ack_to_ff;
   assign svc_eff = (svc_to_ff == 16'd0) ? 16'd1 : svc_to_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff   <= '0;
         ack_to_ff <= 16'd200;
         svc_to_ff <= 16'd5000;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_MASK:   mask_ff   <= csr_data;
            CSR_ACK_TO: ack_to_ff <= csr_data[15:0];
            CSR_SVC_TO: svc_to_ff <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         typ_ff <= req_type; svc_ff <= req_service; fn_ff <= req_func;
         fid_ff <= req_frame_id; len_ff <= req_length;
         acc_ff <= req_handler_accepts; wait_ff <= req_wait_for_answer;
      end
   end

   // slot lookup over used slots (independent compares, priority pick)
   logic            f_hit;
   logic [SlotW-1:0] f_idx;
   logic            free_hit;
   logic [SlotW-1:0] free_idx;
   always_comb begin
      f_hit = 1'b0; f_idx = '0; free_hit = 1'b0; free_idx = '0;
      for (int i = Slots-1; i >= 0; i--) begin
         if ((5'(i) < used_ff) && sl_svc_ff[i] == svc_ff) begin
            f_hit = 1'b1; f_idx = SlotW'(i);
         end
         if (!sl_act_ff[i]) begin
            free_hit = 1'b1; free_idx = SlotW'(i);
         end
      end
   end

   // service memory read address: item service, or walk index
   logic [SvcW-1:0] srv_raddr;
   logic [SvcW-1:0] srv_rd_addr;
   assign srv_raddr = cmd.svc_step ? walk_ff + SvcW'(1) : svc_ff;
   // a tick preloads entry 0 in its accept cycle; other items read their service
   assign srv_rd_addr = accept ? ((req_type == TYPE_TICK) ? SvcW'(0) : req_service)
                               : srv_raddr;
   always_ff @(posedge clock) begin
      srv_rd_ff <= srv_rd_addr;
      srv_id_rd <= srv_id_mem[srv_rd_addr];
      srv_cd_rd <= srv_cd_mem[srv_rd_addr];
   end
   // never-written entries read as zero through the valid bits
   logic [15:0] cd_now;
   logic [7:0]  id_now;
   assign cd_now = srv_vld_ff[srv_rd_ff] ? srv_cd_rd : 16'd0;
   assign id_now = srv_vld_ff[srv_rd_ff] ? srv_id_rd : 8'd0;

   // service memory write
   logic            sw_en;
   logic [SvcW-1:0] sw_addr;
   logic [7:0]      sw_id;
   logic [15:0]     sw_cd;

   // result drive
   logic       o_v, o_last;
   logic [1:0] o_kind, o_fn;
   logic [5:0] o_svc;
   logic [7:0] o_id, o_len;
   logic [2:0] o_code;

   logic [SlotW-1:0] s_sel;
   logic             slot_ok;
   logic             fmatch;
   always_comb begin
      sw_en = 1'b0; sw_addr = svc_ff; sw_id = id_now; sw_cd = cd_now;
      o_v = 1'b0; o_last = 1'b1; o_kind = KIND_HDR; o_fn = FN_REQ; o_svc = svc_ff;
      o_id = 8'd0; o_len = 8'd0; o_code = RC_OK;
      s_sel = f_idx; slot_ok = 1'b0;
      fmatch = f_hit && sl_id_ff[f_idx] == fid_ff && sl_act_ff[f_idx];
      if (cmd.exec) begin
         unique case (typ_ff)
            TYPE_FRAME: begin
               if (len_ff >= 8'd2) begin
                  if (fn_ff == FN_REQ) begin
                     o_v = 1'b1; o_id = fid_ff; o_len = 8'd2;
                     if (mask_ff[svc_ff] && acc_ff) begin
                        o_fn = FN_ACK; sw_en = 1'b1; sw_id = fid_ff; sw_cd = svc_eff;
                     end else begin
                        o_fn = FN_NA;
                     end
                  end else if (fmatch) begin
                     o_kind = KIND_REP; o_svc = sl_svc_ff[f_idx]; o_id = sl_id_ff[f_idx];
                     priority case (fn_ff)
                        FN_ACK: begin
                           o_v = (sl_ack_ff[f_idx] != 0) && (sl_rsp_ff[f_idx] == 0);
                           o_code = RC_OK;
                        end
                        FN_RSP: begin
                           o_v = sl_rsp_ff[f_idx] != 0; o_code = RC_RSP;
                        end
                        default: begin
                           o_v = (sl_ack_ff[f_idx] != 0) || (sl_rsp_ff[f_idx] != 0);
                           o_code = RC_UNAVAIL;
                        end
                     endcase
                  end
               end
            end
            TYPE_SEND: begin
               if (len_ff <= 8'(MaxPayload)) begin
                  if (f_hit) begin
                     slot_ok = !sl_act_ff[f_idx];
                  end else if (used_ff >= 5'(Slots)) begin
                     slot_ok = free_hit; s_sel = free_idx;
                  end else begin
                     slot_ok = 1'b1; s_sel = used_ff[SlotW-1:0];
                  end
               end
               o_v = 1'b1;
               if (slot_ok) begin
                  o_id = sl_id_ff[s_sel] + 8'd1; o_len = len_ff + 8'd2;
               end else begin
                  o_kind = KIND_REF;
               end
            end
            TYPE_RESP: begin
               if (cd_now != 16'd0) begin
                  sw_en = 1'b1; sw_cd = 16'd0;
                  if (len_ff <= 8'(MaxPayload)) begin
                     o_v = 1'b1; o_fn = FN_RSP; o_id = id_now; o_len = len_ff + 8'd2;
                  end
               end
            end
            default: ;
         endcase
      end else if (cmd.svc_step) begin
         sw_addr = walk_ff;
         if (cd_now != 16'd0) begin
            sw_en = 1'b1; sw_cd = cd_now - 16'd1;
         end
      end else if (cmd.finish) begin
         o_v = pend_ff; o_kind = KIND_REP; o_svc = prep_svc_ff;
         o_id = prep_id_ff; o_code = prep_code_ff;
      end
   end

   // service walk: read of entry k+1 issued while k is updated
   always_ff @(posedge clock) begin
      if (sw_en) begin
         srv_id_mem[sw_addr] <= sw_id;
         srv_cd_mem[sw_addr] <= sw_cd;
      end
   end
   always_ff @(posedge clock) begin
      if (reset) srv_vld_ff <= '0;
      else if (sw_en) srv_vld_ff[sw_addr] <= 1'b1;
   end

   // the walk starts at entry 0, read in the accept cycle; each step reads
   // the entry after the one it updates
   always_ff @(posedge clock) begin
      if (accept) walk_ff <= '0;
      else if (cmd.svc_step) walk_ff <= walk_ff + SvcW'(1);
   end
   assign sts.svc_last = (walk_ff == SvcW'(Services-1));
   assign sts.slot_last = (sidx_ff == SlotW'(Slots-1));

   // slot walk during a tick
   logic tk_rep;
   logic [2:0] tk_code;
   logic tk_live;
   always_comb begin
      tk_live = cmd.slot_step && (5'(sidx_ff) < used_ff) && sl_act_ff[sidx_ff];
      tk_rep = 1'b0; tk_code = RC_ACK_TO;
      if (tk_live) begin
         if (sl_ack_ff[sidx_ff] != 0) begin
            tk_rep = sl_ack_ff[sidx_ff] == 16'd1;
         end else if (sl_rsp_ff[sidx_ff] != 0) begin
            tk_rep = sl_rsp_ff[sidx_ff] == 16'd1; tk_code = RC_RSP_TO;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sl_act_ff <= '0; used_ff <= '0; pend_ff <= 1'b0; nrep_ff <= '0;
         for (int i = 0; i < Slots; i++) begin
            sl_svc_ff[i] <= '0; sl_id_ff[i] <= '0; sl_ack_ff[i] <= '0; sl_rsp_ff[i] <= '0;
         end
      end else begin
         if (accept) begin
            sidx_ff <= '0; nrep_ff <= '0; pend_ff <= 1'b0;
         end
         if (cmd.exec && o_v && o_kind == KIND_REP) begin
            sl_act_ff[f_idx] <= 1'b0; sl_ack_ff[f_idx] <= '0; sl_rsp_ff[f_idx] <= '0;
         end else if (cmd.exec && typ_ff == TYPE_FRAME && fn_ff == FN_ACK && fmatch
                      && len_ff >= 8'd2) begin
            sl_ack_ff[f_idx] <= '0;
         end
         if (cmd.exec && typ_ff == TYPE_SEND && slot_ok) begin
            sl_svc_ff[s_sel] <= svc_ff; sl_id_ff[s_sel] <= sl_id_ff[s_sel] + 8'd1;
            sl_ack_ff[s_sel] <= ack_eff;
            sl_rsp_ff[s_sel] <= wait_ff ? svc_eff : 16'd0;
            sl_act_ff[s_sel] <= 1'b1;
            if (!f_hit && used_ff < 5'(Slots)) used_ff <= used_ff + 5'd1;
         end
         if (cmd.slot_step) begin
            sidx_ff <= sidx_ff + SlotW'(1);
            if (tk_live && !tk_rep) begin
               if (sl_ack_ff[sidx_ff] != 0) sl_ack_ff[sidx_ff] <= sl_ack_ff[sidx_ff] - 16'd1;
               else if (sl_rsp_ff[sidx_ff] != 0)
                  sl_rsp_ff[sidx_ff] <= sl_rsp_ff[sidx_ff] - 16'd1;
            end
            if (tk_rep) begin
               sl_act_ff[sidx_ff] <= 1'b0; sl_ack_ff[sidx_ff] <= '0; sl_rsp_ff[sidx_ff] <= '0;
               if (nrep_ff < 5'd16) begin
                  nrep_ff <= nrep_ff + 5'd1; pend_ff <= 1'b1;
                  prep_svc_ff <= sl_svc_ff[sidx_ff]; prep_id_ff <= sl_id_ff[sidx_ff];
                  prep_code_ff <= tk_code;
               end
            end
         end
      end
   end

   // a tick report is released, without last, when the next one replaces it
   logic rel_v;
   assign rel_v = cmd.slot_step && tk_rep && pend_ff && nrep_ff < 5'd16;

   always_ff @(posedge clock) begin
      if (reset) rsp_valid <= 1'b0;
      else       rsp_valid <= o_v || rel_v;
   end
   always_ff @(posedge clock) begin
      if (rel_v) begin
         rsp_out_kind <= KIND_REP; rsp_out_service <= prep_svc_ff; rsp_out_func <= FN_REQ;
         rsp_out_id <= prep_id_ff; rsp_out_length <= 8'd0; rsp_report_code <= prep_code_ff;
         rsp_last <= 1'b0;
      end else begin
         rsp_out_kind <= o_kind; rsp_out_service <= o_svc; rsp_out_func <= o_fn;
         rsp_out_id <= o_id; rsp_out_length <= o_len; rsp_report_code <= o_code;
         rsp_last <= o_last;
      end
   end
endmodule

// ----- rtl/p2p_request_response_tracker.sv -----
// Top level of the point-to-point request/response tracker.
// Depends on p2prt_pkg, p2prt_ctrl and p2prt_dp.
//
// Usage:
//  - Input: drive the req_ word with start high while busy is low; the word
//    is taken at that edge. Frame, send and response-ready words are handled
//    in order: the item is registered and the service memory read, then the
//    result is decided and registered.
//  - A tick walks the 64 service countdowns, one memory entry a cycle, then
//    the 16 request slots, one a cycle, then closes.
//  - Results: rsp_valid marks each result for exactly one cycle; rsp_last
//    flags the final word of an item. The receiver cannot stall, so results
//    are never held. Up to sixteen timeout reports leave during a tick.
//  - Configuration: csr_write with csr_index and csr_data, while idle.
//  - Reset (synchronous, active high) clears slots, the fill count, the
//    service valid bits and the controller; registers return to defaults.
module p2p_request_response_tracker (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_type,
   input  logic [5:0]  req_service,
   input  logic [1:0]  req_func,
   input  logic [7:0]  req_frame_id,
   input  logic [7:0]  req_length,
   input  logic        req_handler_accepts,
   input  logic        req_wait_for_answer,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_data,
   output logic        rsp_valid,
   output logic [1:0]  rsp_out_kind,
   output logic [5:0]  rsp_out_service,
   output logic [1:0]  rsp_out_func,
   output logic [7:0]  rsp_out_id,
   output logic [7:0]  rsp_out_length,
   output logic [2:0]  rsp_report_code,
   output logic        rsp_last
);
   import p2prt_pkg::*;

   cmd_type    cmd;
   status_type sts;
   logic       accept;

   assign accept = start && !busy;

   p2prt_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .req_type(req_type),
      .sts(sts), .cmd(cmd), .busy(busy)
   );

   p2prt_dp u_dp (
      .clock(clock), .reset(reset), .accept(accept), .req_type(req_type),
      .req_service(req_service), .req_func(req_func), .req_frame_id(req_frame_id),
      .req_length(req_length), .req_handler_accepts(req_handler_accepts),
      .req_wait_for_answer(req_wait_for_answer), .csr_write(csr_write),
      .csr_index(csr_index), .csr_data(csr_data), .cmd(cmd), .sts(sts),
      .rsp_valid(rsp_valid), .rsp_out_kind(rsp_out_kind),
      .rsp_out_service(rsp_out_service), .rsp_out_func(rsp_out_func),
      .rsp_out_id(rsp_out_id), .rsp_out_length(rsp_out_length),
      .rsp_report_code(rsp_report_code), .rsp_last(rsp_last)
   );

`ifndef SYNTHESIS
   // a word is never taken while an earlier item is still at work
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !accept) else $error("word taken while busy");
   // a completion report never carries a transmit length
   a_report_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_out_kind == KIND_REP) |-> rsp_out_length == 8'd0)
      else $error("report with length");
   // an accepted item makes the block busy in the next cycle
   a_busy_after: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy) else $error("not busy after accept");
`endif
endmodule
